// ----- sv/sta_pkg.sv -----
// Shared constants, types and helpers for the strided tensor address generator.
package sta_pkg;

    localparam int DIM_SLOTS    = 4;
    localparam int MAX_DIMS_DEF = 4;
    localparam int REG_W        = 32;
    localparam int OFF_W        = 48;
    localparam int CFG_IDX_W    = 4;
    localparam int FIFO_DEPTH   = 4;

    localparam logic [OFF_W-1:0] OFFSET_MAX = {OFF_W{1'b1}};

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DIM0   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DIM1   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DIM2   = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_DIM3   = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_DIM0 = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_DIM1 = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_DIM2 = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_DIM3 = 4'd7;

    // Queue status between front and back
    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // A zero extent behaves as extent one
    function automatic logic [REG_W-1:0] fix_size(input logic [REG_W-1:0] sz);
        fix_size = (sz == '0) ? {{(REG_W-1){1'b0}}, 1'b1} : sz;
    endfunction

endpackage

// ----- sv/sta_front.sv -----
// Front end: pipelined mixed-radix divider, one quotient bit per stage.
module sta_front #(
    parameter int MAX_DIMS = sta_pkg::MAX_DIMS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic [sta_pkg::REG_W-1:0]           in_index,
    input  logic [sta_pkg::REG_W-1:0]           divisor [MAX_DIMS],
    output logic                                out_valid,
    output logic [MAX_DIMS*sta_pkg::REG_W-1:0]  out_coord
);
    import sta_pkg::*;

    localparam int STAGES = MAX_DIMS * REG_W;
    localparam int CW     = MAX_DIMS * REG_W;

    logic             v_reg   [1:STAGES];
    logic [REG_W-1:0] rem_reg [1:STAGES];
    logic [REG_W-1:0] nq_reg  [1:STAGES];
    logic [CW-1:0]    crd_reg [1:STAGES];

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic             v_in;
        logic [REG_W-1:0] r_in;
        logic [REG_W-1:0] n_in;
        logic [CW-1:0]    c_in;
        logic [REG_W:0]   r33;
        logic [REG_W:0]   d33;
        logic [REG_W:0]   diff;
        logic             ge;
        logic [REG_W-1:0] rem_next;

        // Select stage source: input, new dimension, or running division
        if (k == 0) begin : g_first
            assign v_in = in_valid;
            assign r_in = '0;
            assign n_in = in_index;
            assign c_in = '0;
        end else if (k % REG_W == 0) begin : g_bound
            assign v_in = v_reg[k];
            assign r_in = '0;
            assign n_in = nq_reg[k];
            always_comb
            begin
                c_in = crd_reg[k];
                c_in[(k/REG_W-1)*REG_W +: REG_W] = rem_reg[k];
            end
        end else begin : g_mid
            assign v_in = v_reg[k];
            assign r_in = rem_reg[k];
            assign n_in = nq_reg[k];
            assign c_in = crd_reg[k];
        end

        // Shift in one dividend bit, trial subtract
        assign r33      = {r_in, n_in[REG_W-1]};
        assign d33      = {1'b0, divisor[k/REG_W]};
        assign diff     = r33 - d33;
        assign ge       = (r33 >= d33);
        assign rem_next = ge ? diff[REG_W-1:0] : r33[REG_W-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k+1] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k+1] <= rem_next;
                nq_reg[k+1]  <= {n_in[REG_W-2:0], ge};
                crd_reg[k+1] <= c_in;
            end
        end
    end

    // Last remainder is the outermost coordinate; its quotient is dropped
    assign out_valid = v_reg[STAGES];
    always_comb
    begin
        out_coord = crd_reg[STAGES];
        out_coord[(MAX_DIMS-1)*REG_W +: REG_W] = rem_reg[STAGES];
    end

endmodule

// ----- sv/sta_fifo.sv -----
// Short queue decoupling the divider pipeline from the offset back end.
module sta_fifo #(
    parameter int WIDTH = sta_pkg::REG_W
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [WIDTH-1:0]  push_data,
    input  logic              pop,
    output logic [WIDTH-1:0]  pop_data,
    output sta_pkg::fifo_stat_t stat
);
    import sta_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    logic [WIDTH-1:0] mem [FIFO_DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW:0]      count_reg;
    logic [PW:0]      count_next;

    assign stat.full  = (count_reg == (PW+1)'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- sv/sta_back.sv -----
// Back end: stride products, summation and saturation into the output register.
module sta_back #(
    parameter int MAX_DIMS = sta_pkg::MAX_DIMS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    input  logic [MAX_DIMS*sta_pkg::REG_W-1:0]  q_coord,
    output logic                                q_pop,
    input  logic [sta_pkg::REG_W-1:0]           stride [MAX_DIMS],
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sta_pkg::OFF_W-1:0]           out_offset,
    output logic                                out_over
);
    import sta_pkg::*;

    localparam int PROD_W = 2 * REG_W;
    localparam int SUM_W  = OFF_W + $clog2(MAX_DIMS) + 1;

    logic              back_adv;
    logic              mul_valid_reg;
    logic [PROD_W-1:0] prod_reg [MAX_DIMS];
    logic [SUM_W-1:0]  sum;
    logic              big;
    logic              over_next;
    logic              out_valid_reg;
    logic [OFF_W-1:0]  out_offset_reg;
    logic              out_over_reg;

    // Stall the back end only while a result waits at the output
    assign back_adv = !out_valid_reg || out_ready;
    assign q_pop    = back_adv && !q_empty;

    always_ff @(posedge clk)
    begin
        if (back_adv)
        begin
            for (int g = 0; g < MAX_DIMS; g++)
            begin
                prod_reg[g] <= PROD_W'(q_coord[g*REG_W +: REG_W]) * PROD_W'(stride[g]);
            end
        end
    end

    // Sum products, flag any product or total past the offset range
    always_comb
    begin
        sum = '0;
        big = 1'b0;
        for (int g = 0; g < MAX_DIMS; g++)
        begin
            sum = sum + SUM_W'(prod_reg[g][OFF_W-1:0]);
            big = big | (prod_reg[g][PROD_W-1:OFF_W] != '0);
        end
        over_next = big || (sum > SUM_W'(OFFSET_MAX));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (back_adv)
        begin
            mul_valid_reg <= !q_empty;
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_adv)
        begin
            out_over_reg   <= over_next;
            out_offset_reg <= over_next ? OFFSET_MAX : sum[OFF_W-1:0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_offset = out_offset_reg;
    assign out_over   = out_over_reg;

endmodule

// ----- sv/strided_tensor_address_generator.sv -----
// Top level of the strided tensor address generator.
//
// Usage: write the extents and strides on the configuration port while the
// block is idle (cfg_we, cfg_index 0..7, cfg_data; other indexes ignored).
// Stream linear element indexes into s_tdata; each transaction yields one
// source element offset on m_tdata, with m_tuser set when the offset
// saturated at the top of the 48-bit range.
// Throughput: one transaction per cycle while m_tready stays high.
// Path from input to output: the divider pipeline (128 divider stages
// at four dimensions), one queue slot, the multiply stage and the output
// register. The divider pipeline resolves one quotient bit per stage.
// Reset: extents return to 1, strides to 0, all pipelines and the queue
// empty. When m_tready is low the back end holds its result, the four-entry
// queue fills, and only then does s_tready drop; the divider pipeline then
// holds as a whole until the queue has room again.
module strided_tensor_address_generator #(
    parameter int MAX_DIMS = sta_pkg::MAX_DIMS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [sta_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sta_pkg::REG_W-1:0]      cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // [31:0] element_index
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [47:0]                    m_tdata,   // [47:0] source_offset
    output logic                           m_tuser    // [0] offset_overflow
);
    import sta_pkg::*;

    localparam int CW = MAX_DIMS * REG_W;

    logic [REG_W-1:0] size_reg   [DIM_SLOTS];
    logic [REG_W-1:0] stride_reg [DIM_SLOTS];
    logic [REG_W-1:0] divisor    [MAX_DIMS];
    logic [REG_W-1:0] stride     [MAX_DIMS];
    logic             adv;
    logic             f_valid;
    logic [CW-1:0]    f_coord;
    logic [CW-1:0]    q_coord;
    logic             q_pop;
    fifo_stat_t       q_stat;

    // Decode configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < DIM_SLOTS; d++)
            begin
                size_reg[d]   <= {{(REG_W-1){1'b0}}, 1'b1};
                stride_reg[d] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index) inside
                [CFG_SIZE_DIM0:CFG_SIZE_DIM3]:
                    size_reg[cfg_index[1:0]] <= cfg_data;
                [CFG_STRIDE_DIM0:CFG_STRIDE_DIM3]:
                    stride_reg[cfg_index[1:0]] <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    // Order dimensions innermost first
    always_comb
    begin
        for (int g = 0; g < MAX_DIMS; g++)
        begin
            divisor[g] = fix_size(size_reg[DIM_SLOTS-1-g]);
            stride[g]  = stride_reg[DIM_SLOTS-1-g];
        end
    end

    assign adv      = !q_stat.full;
    assign s_tready = adv;

    sta_front #(.MAX_DIMS(MAX_DIMS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .in_index  (s_tdata),
        .divisor   (divisor),
        .out_valid (f_valid),
        .out_coord (f_coord)
    );

    sta_fifo #(.WIDTH(CW)) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_valid && adv),
        .push_data (f_coord),
        .pop       (q_pop),
        .pop_data  (q_coord),
        .stat      (q_stat)
    );

    sta_back #(.MAX_DIMS(MAX_DIMS)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_stat.empty),
        .q_coord    (q_coord),
        .q_pop      (q_pop),
        .stride     (stride),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_offset (m_tdata),
        .out_over   (m_tuser)
    );

endmodule

// ----- sv/sta_checker.sv -----
// Port-level checker for the strided tensor address generator, with its bind.
module sta_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic        m_tuser
);
    logic [7:0] inflight_reg;

    // Track transactions in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_reg + 8'(s_tvalid && s_tready)
                                         - 8'(m_tvalid && m_tready);
        end
    end

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> inflight_reg != 8'd0)
        else $error("result without a pending input transaction");

    a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 48'hFFFF_FFFF_FFFF)
        else $error("overflow flagged but offset not saturated");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

bind strided_tensor_address_generator sta_checker u_sta_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
